/* rtl/websocket_frame_fragmenter_macros.svh */
// ----------------------------------------------------------------------------
// websocket frame fragmenter assertion macros
// shared concurrent checks, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_FRAGMENTER_MACROS_SVH
`define WEBSOCKET_FRAME_FRAGMENTER_MACROS_SVH

// condition that must hold at every edge out of reset
`define WSFF_CHECK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define WSFF_CHECK_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error(msg);

`endif

/* rtl/wsff_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsff_pkg
// types, constants and header byte helpers for the frame fragmenter
// ----------------------------------------------------------------------------
package wsff_pkg;

  localparam int unsigned MaxResults = 15;
  localparam int unsigned CountW     = 4;
  localparam int unsigned LenW       = 31;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;

  // register indexes (paddr[2])
  localparam logic RegMustMask = 1'b0;
  localparam logic RegMaxFrame = 1'b1;

  localparam logic            MustMaskReset = 1'b1;
  localparam logic [LenW-1:0] MaxFrameReset = LenW'(512 * 512 * 2);

  localparam logic [3:0] OpCont   = 4'h0;
  localparam logic [3:0] OpText   = 4'h1;
  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [7:0] OpMask   = 8'h0F;
  localparam logic [7:0] FinBit   = 8'h80;
  localparam logic [7:0] MaskBit  = 8'h80;

  localparam logic [6:0]      LenShortMax = 7'd125;
  localparam logic [6:0]      Len16Code   = 7'd126;
  localparam logic [6:0]      Len64Code   = 7'd127;
  localparam logic [LenW-1:0] Len16Max    = LenW'(32'h0000FFFF);

  localparam logic [CountW-1:0] Ext16Bytes = CountW'(2);
  localparam logic [CountW-1:0] Ext64Bytes = CountW'(8);
  localparam logic [CountW-1:0] KeyBytes   = CountW'(4);

  typedef struct packed {
    logic            must_mask;
    logic [LenW-1:0] max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CountW-1:0]          count;
    logic                       frame_end;
  } burst_t;

  function automatic logic [7:0] key_byte(logic [31:0] key, logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = key[7:0];
      2'd1:    b = key[15:8];
      2'd2:    b = key[23:16];
      default: b = key[31:24];
    endcase
    return b;
  endfunction

  // extended length byte j, big-endian, for a 2 or 8 byte length field
  function automatic logic [7:0] ext_byte(logic [LenW-1:0] size, logic [CountW-1:0] ext_n,
                                          logic [CountW-1:0] j);
    logic [63:0] len64;
    logic [2:0]  pos;
    logic [7:0]  b;
    len64 = {33'b0, size};
    pos   = (ext_n == Ext16Bytes) ? 3'(j + CountW'(6)) : j[2:0];
    case (pos)
      3'd0:    b = len64[63:56];
      3'd1:    b = len64[55:48];
      3'd2:    b = len64[47:40];
      3'd3:    b = len64[39:32];
      3'd4:    b = len64[31:24];
      3'd5:    b = len64[23:16];
      3'd6:    b = len64[15:8];
      default: b = len64[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] header_byte(logic [CountW-1:0] pos, logic [7:0] b0,
                                             logic [7:0] b1, logic [LenW-1:0] size,
                                             logic [CountW-1:0] ext_n, logic [31:0] key);
    logic [CountW-1:0] j;
    logic [CountW-1:0] k;
    logic [7:0]        b;
    j = pos - CountW'(2);
    k = j - ext_n;
    if (pos == CountW'(0)) begin
      b = b0;
    end else if (pos == CountW'(1)) begin
      b = b1;
    end else if (j < ext_n) begin
      b = ext_byte(size, ext_n, j);
    end else begin
      b = key_byte(key, k[1:0]);
    end
    return b;
  endfunction

endpackage

/* rtl/wsff_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsff_in_if / wsff_out_if
// valid/ready channels for message items and wire stream bytes
// ----------------------------------------------------------------------------
interface wsff_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        message_start;
  logic [30:0] message_length;
  logic        is_binary;
  logic [31:0] mask_key;

  modport source (output valid, output payload_byte, output message_start,
                  output message_length, output is_binary, output mask_key,
                  input ready);
  modport sink   (input valid, input payload_byte, input message_start,
                  input message_length, input is_binary, input mask_key,
                  output ready);
endinterface

interface wsff_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       last;

  modport source (output valid, output out_byte, output frame_end, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_end, input last,
                  output ready);
endinterface

/* rtl/wsff_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsff_cfg
// apb register file: mask enable and frame size limit
// ----------------------------------------------------------------------------
module wsff_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wsff_pkg::AddrW-1:0]   paddr,
  input  logic [wsff_pkg::DataW-1:0]   pwdata,
  output logic [wsff_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output wsff_pkg::cfg_t               cfg
);

  logic                      must_mask;
  logic [wsff_pkg::LenW-1:0] max_frame_bytes;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      must_mask       <= wsff_pkg::MustMaskReset;
      max_frame_bytes <= wsff_pkg::MaxFrameReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        wsff_pkg::RegMustMask: must_mask       <= pwdata[0];
        wsff_pkg::RegMaxFrame: max_frame_bytes <= pwdata[wsff_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      wsff_pkg::RegMustMask: prdata = {31'b0, must_mask};
      wsff_pkg::RegMaxFrame: prdata = {1'b0, max_frame_bytes};
      default:               prdata = '0;
    endcase
  end

  assign cfg.must_mask       = must_mask;
  assign cfg.max_frame_bytes = max_frame_bytes;

endmodule

/* rtl/wsff_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsff_encoder
// message/frame state and single-pass build of each request's byte burst
// ----------------------------------------------------------------------------
`include "websocket_frame_fragmenter_macros.svh"

module wsff_encoder (
  input  logic              clk,
  input  logic              rst,
  input  wsff_pkg::cfg_t    cfg,
  wsff_in_if.sink           message,
  input  logic              space,
  output logic              load,
  output wsff_pkg::burst_t  burst_next
);

  localparam int unsigned LenW   = wsff_pkg::LenW;
  localparam int unsigned CountW = wsff_pkg::CountW;

  logic [LenW-1:0] message_bytes_left;
  logic [LenW-1:0] frame_bytes_left;
  logic [1:0]      key_byte_index;
  logic [31:0]     frame_key;
  logic            first_frame_pending;
  logic            message_is_binary;

  logic [LenW-1:0] message_bytes_left_next;
  logic [LenW-1:0] frame_bytes_left_next;
  logic [1:0]      key_byte_index_next;
  logic [31:0]     frame_key_next;
  logic            first_frame_pending_next;
  logic            message_is_binary_next;

  logic              start, push, produce, new_frame, fin, has_payload, mask_on;
  logic [LenW-1:0]   mbl_e, fbl_e, fbl_h, limit, size;
  logic              ffp_e;
  logic [1:0]        kbi_e, kbi_h;
  logic [31:0]       key_e;
  logic [3:0]        opcode;
  logic [6:0]        len_code;
  logic [7:0]        b0, b1, pay;
  logic [CountW-1:0] ext_n, key_n, hdr_n;

  assign message.ready = space;
  assign push          = message.valid && message.ready;
  assign start         = message.message_start;
  assign produce       = start || (message_bytes_left != '0);
  assign load          = push && produce;

  always_comb begin
    // a start restarts the message whatever was in flight
    mbl_e     = start ? message.message_length : message_bytes_left;
    fbl_e     = start ? '0 : frame_bytes_left;
    ffp_e     = start ? 1'b1 : first_frame_pending;
    kbi_e     = start ? 2'd0 : key_byte_index;
    new_frame = (fbl_e == '0);

    limit = (cfg.max_frame_bytes == '0) ? LenW'(1) : cfg.max_frame_bytes;
    size  = (mbl_e < limit) ? mbl_e : limit;
    fin   = (mbl_e <= limit);

    key_e   = new_frame ? (cfg.must_mask ? message.mask_key : 32'h0) : frame_key;
    mask_on = (key_e != 32'h0);

    if (!ffp_e) begin
      opcode = wsff_pkg::OpCont;
    end else if (start ? message.is_binary : message_is_binary) begin
      opcode = wsff_pkg::OpBinary;
    end else begin
      opcode = wsff_pkg::OpText;
    end
    b0 = ({4'b0, opcode} & wsff_pkg::OpMask) | (fin ? wsff_pkg::FinBit : 8'h00);

    if (size <= LenW'(wsff_pkg::LenShortMax)) begin
      len_code = size[6:0];
      ext_n    = '0;
    end else if (size <= wsff_pkg::Len16Max) begin
      len_code = wsff_pkg::Len16Code;
      ext_n    = wsff_pkg::Ext16Bytes;
    end else begin
      len_code = wsff_pkg::Len64Code;
      ext_n    = wsff_pkg::Ext64Bytes;
    end
    b1    = (mask_on ? wsff_pkg::MaskBit : 8'h00) | {1'b0, len_code};
    key_n = mask_on ? wsff_pkg::KeyBytes : '0;
    hdr_n = new_frame ? (CountW'(2) + ext_n + key_n) : '0;

    fbl_h       = new_frame ? size : fbl_e;
    kbi_h       = new_frame ? 2'd0 : kbi_e;
    has_payload = (fbl_h != '0);
    pay         = message.payload_byte ^ wsff_pkg::key_byte(key_e, kbi_h);

    for (int i = 0; i < wsff_pkg::MaxResults; i++) begin
      if (CountW'(i) < hdr_n) begin
        burst_next.bytes[i] = wsff_pkg::header_byte(CountW'(i), b0, b1, size, ext_n, key_e);
      end else begin
        burst_next.bytes[i] = pay;
      end
    end
    burst_next.count     = produce ? (hdr_n + CountW'(has_payload)) : '0;
    // an empty frame ends on its last header byte
    burst_next.frame_end = has_payload ? (fbl_h == LenW'(1)) : 1'b1;

    frame_bytes_left_next    = has_payload ? (fbl_h - LenW'(1)) : fbl_h;
    message_bytes_left_next  = has_payload ? (mbl_e - LenW'(1)) : mbl_e;
    key_byte_index_next      = has_payload ? (kbi_h + 2'd1) : kbi_h;
    frame_key_next           = key_e;
    first_frame_pending_next = new_frame ? 1'b0 : ffp_e;
    message_is_binary_next   = start ? message.is_binary : message_is_binary;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_bytes_left  <= '0;
      frame_bytes_left    <= '0;
      key_byte_index      <= 2'd0;
      frame_key           <= '0;
      first_frame_pending <= 1'b1;
      message_is_binary   <= 1'b0;
    end else if (load) begin
      message_bytes_left  <= message_bytes_left_next;
      frame_bytes_left    <= frame_bytes_left_next;
      key_byte_index      <= key_byte_index_next;
      frame_key           <= frame_key_next;
      first_frame_pending <= first_frame_pending_next;
      message_is_binary   <= message_is_binary_next;
    end
  end

  `WSFF_CHECK(a_frame_within_message, frame_bytes_left <= message_bytes_left, "frame count exceeds message count")
  `WSFF_CHECK_NEXT(a_first_frame_done, load, !first_frame_pending, "first frame still pending after a request")
  `WSFF_CHECK_NEXT(a_empty_message, load && start && (message.message_length == '0), (message_bytes_left == '0) && (frame_bytes_left == '0), "empty message left bytes behind")

endmodule

/* rtl/wsff_serializer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsff_serializer
// burst register and one-byte output register onto the wire stream
// ----------------------------------------------------------------------------
`include "websocket_frame_fragmenter_macros.svh"

module wsff_serializer (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  wsff_pkg::burst_t  burst_next,
  output logic              space,
  wsff_out_if.source        stream
);

  localparam int unsigned CountW = wsff_pkg::CountW;

  wsff_pkg::burst_t  burst;
  logic              burst_valid;
  logic [CountW-1:0] byte_idx;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       last;

  logic oload, advance, blast;

  assign oload   = !out_valid || stream.ready;
  assign advance = burst_valid && oload;
  assign blast   = (byte_idx == (burst.count - CountW'(1)));
  // next request may enter as the final byte of this burst moves out
  assign space   = !burst_valid || (blast && oload);

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
      byte_idx    <= '0;
    end else if (load && (burst_next.count != '0)) begin
      burst_valid <= 1'b1;
      byte_idx    <= '0;
    end else if (advance && blast) begin
      burst_valid <= 1'b0;
    end else if (advance) begin
      byte_idx <= byte_idx + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst <= burst_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (oload) begin
      out_valid <= burst_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (oload) begin
      out_byte  <= burst.bytes[byte_idx];
      frame_end <= blast && burst.frame_end;
      last      <= blast;
    end
  end

  assign stream.valid     = out_valid;
  assign stream.out_byte  = out_byte;
  assign stream.frame_end = frame_end;
  assign stream.last      = last;

  `WSFF_CHECK(a_count_range, !burst_valid || ((burst.count != '0) && (burst.count <= CountW'(wsff_pkg::MaxResults))), "burst count out of range")
  `WSFF_CHECK(a_index_in_burst, !burst_valid || (byte_idx < burst.count), "byte index past burst end")
  `WSFF_CHECK_NEXT(a_last_marks_end, advance && blast && burst.frame_end, stream.valid && stream.frame_end && stream.last, "frame end lost on final byte")

endmodule

/* rtl/websocket_frame_fragmenter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_fragmenter
// rfc 6455 frame encoder that splits messages into size-limited frames
// ----------------------------------------------------------------------------
// Takes one payload byte per request on message and sends the wire bytes on
// stream, one byte per cycle while stream.ready holds. A request that opens
// a frame produces its header (2 to 14 bytes: opcode, length code, 16 or 64
// bit length, masking key) and then its masked payload byte, if it has one.
// A burst register holds a request's bytes while the one-byte output register
// sends them, and the next request is taken as the last byte leaves, so a
// new request waits until the previous one is through. Length and type are
// read from the first request of a message, the key from the request that
// opens a frame. Registers on the apb port: must_mask at 0x0, max_frame_bytes
// at 0x4; write them only while the block is idle.
module websocket_frame_fragmenter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wsff_pkg::AddrW-1:0]  paddr,
  input  logic [wsff_pkg::DataW-1:0]  pwdata,
  output logic [wsff_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  wsff_in_if.sink                     message,
  wsff_out_if.source                  stream
);

  wsff_pkg::cfg_t   cfg;
  wsff_pkg::burst_t burst_next;
  logic             load;
  logic             space;

  wsff_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wsff_encoder u_encoder (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .message    (message),
    .space      (space),
    .load       (load),
    .burst_next (burst_next)
  );

  wsff_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .burst_next (burst_next),
    .space      (space),
    .stream     (stream)
  );

endmodule
